// ----- rtl/jmff_pkg.sv -----
// Shared constants and types for the JPEG marker frame filter.
package jmff_pkg;

  localparam logic [7:0]  MARK_BYTE         = 8'hFF;
  localparam logic [7:0]  ID_SOI            = 8'hD8;
  localparam logic [7:0]  ID_EOI            = 8'hD9;
  localparam logic [7:0]  ID_SOS            = 8'hDA;
  localparam logic [15:0] LEN_BIAS          = 16'd2;
  localparam logic [7:0]  DISCARD_ID_RESET  = 8'hF0;
  localparam int          OUT_FIFO_DEPTH    = 4;

  typedef enum logic [8:0] {
    ST_HUNT    = 9'b000000001,
    ST_HUNT_FF = 9'b000000010,
    ST_HDR     = 9'b000000100,
    ST_HDR_FF  = 9'b000001000,
    ST_LEN_HI  = 9'b000010000,
    ST_LEN_LO  = 9'b000100000,
    ST_PAYLOAD = 9'b001000000,
    ST_SCAN    = 9'b010000000,
    ST_SCAN_FF = 9'b100000000
  } parse_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

// ----- rtl/jmff_parser.sv -----
// Marker parser: state machine that turns one input byte into up to two results.
module jmff_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  logic                   in_fire,
  input  logic [7:0]             in_byte,
  output jmff_pkg::result_pair_t res
);
  import jmff_pkg::*;

  parse_state_t state, state_next;
  logic [15:0]  remaining_payload, remaining_payload_next;
  logic [7:0]   length_high, length_high_next;
  logic         segment_is_sos, segment_is_sos_next;
  logic         segment_dropped, segment_dropped_next;
  logic [7:0]   discard_marker_id;

  logic [15:0]  seg_len;
  logic [15:0]  len_payload;
  logic [15:0]  payload_dec;
  parse_state_t seg_done_state;

  assign seg_len        = {length_high, in_byte};
  assign len_payload    = (seg_len < LEN_BIAS) ? 16'd0 : seg_len - LEN_BIAS;
  assign payload_dec    = remaining_payload - 16'd1;
  assign seg_done_state = (segment_is_sos && !segment_dropped) ? ST_SCAN : ST_HDR;

  always_comb begin
    state_next             = state;
    remaining_payload_next = remaining_payload;
    length_high_next       = length_high;
    segment_is_sos_next    = segment_is_sos;
    segment_dropped_next   = segment_dropped;
    res                    = '0;
    res.r0.out_byte        = in_byte;
    res.r1.out_byte        = in_byte;
    case (state)
      ST_HUNT_FF: begin
        if (in_byte == ID_SOI) begin
          res.count          = 2'd2;
          res.r0.out_byte    = MARK_BYTE;
          res.r0.frame_start = 1'b1;
          state_next         = ST_HDR;
        end else begin
          state_next = ST_HUNT;
        end
      end
      ST_HDR: begin
        if (in_byte == MARK_BYTE) begin
          state_next = ST_HDR_FF;
        end else begin
          res.count = 2'd1;
        end
      end
      ST_HDR_FF: begin
        if (in_byte == discard_marker_id) begin
          segment_dropped_next = 1'b1;
          segment_is_sos_next  = 1'b0;
        end else begin
          segment_dropped_next = 1'b0;
          segment_is_sos_next  = (in_byte == ID_SOS);
          res.count            = 2'd2;
          res.r0.out_byte      = MARK_BYTE;
        end
        state_next = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        length_high_next = in_byte;
        if (!segment_dropped) begin
          res.count = 2'd1;
        end
        state_next = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        if (!segment_dropped) begin
          res.count = 2'd1;
        end
        remaining_payload_next = len_payload;
        state_next = (len_payload == 16'd0) ? seg_done_state : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        if (!segment_dropped) begin
          res.count = 2'd1;
        end
        remaining_payload_next = payload_dec;
        if (payload_dec == 16'd0) begin
          state_next = seg_done_state;
        end
      end
      ST_SCAN: begin
        res.count = 2'd1;
        if (in_byte == MARK_BYTE) begin
          state_next = ST_SCAN_FF;
        end
      end
      ST_SCAN_FF: begin
        res.count = 2'd1;
        if (in_byte == ID_EOI) begin
          res.r0.frame_end = 1'b1;
          state_next       = ST_HUNT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      default: begin
        state_next = (in_byte == MARK_BYTE) ? ST_HUNT_FF : ST_HUNT;
      end
    endcase
    res.r0.last = (res.count == 2'd1);
    res.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_HUNT;
      remaining_payload <= '0;
      length_high       <= '0;
      segment_is_sos    <= 1'b0;
      segment_dropped   <= 1'b0;
      discard_marker_id <= DISCARD_ID_RESET;
    end else begin
      if (cfg_wr_en) begin
        discard_marker_id <= cfg_wr_data;
      end
      if (in_fire) begin
        state             <= state_next;
        remaining_payload <= remaining_payload_next;
        length_high       <= length_high_next;
        segment_is_sos    <= segment_is_sos_next;
        segment_dropped   <= segment_dropped_next;
      end
    end
  end

endmodule

// ----- rtl/jmff_out_fifo.sv -----
// Result queue: takes up to two results per cycle, releases one per transaction.
module jmff_out_fifo #(
  parameter int DEPTH = jmff_pkg::OUT_FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_fire,
  input  jmff_pkg::result_pair_t push,
  output logic                   can_accept,
  output logic                   head_valid,
  output jmff_pkg::result_t      head,
  input  logic                   pop
);
  import jmff_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  result_t           entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count, count_next;
  logic [CntW-1:0]   push_n;
  logic              pop_fire;

  // Pointer advance that wraps at DEPTH, also for depths that are not a power of two.
  function automatic logic [PtrW-1:0] ptr_add(input logic [PtrW-1:0] p, input logic [1:0] n);
    logic [PtrW:0] s;
    s = (PtrW+1)'(p) + (PtrW+1)'(n);
    if (s >= (PtrW+1)'(DEPTH)) begin
      s = s - (PtrW+1)'(DEPTH);
    end
    return s[PtrW-1:0];
  endfunction

  assign pop_fire   = pop && head_valid;
  assign push_n     = push_fire ? CntW'(push.count) : '0;
  assign count_next = count + push_n - CntW'(pop_fire);
  assign can_accept = (count <= CntW'(DEPTH - 2));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_fire && push.count != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push_fire && push.count == 2'd2) begin
      entries[ptr_add(wr_ptr, 2'd1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= ptr_add(wr_ptr, push_fire ? push.count : 2'd0);
      if (pop_fire) begin
        rd_ptr <= ptr_add(rd_ptr, 2'd1);
      end
      count <= count_next;
    end
  end

endmodule

// ----- rtl/jpeg_marker_frame_filter.sv -----
// Top level of the JPEG marker frame filter: parser plus result queue.
//
// Input stream s_axis carries one stream byte per transaction; output stream
// m_axis carries the bytes of cleaned frames. frame_start marks the 0xFF of
// the SOI that opens a frame, frame_end marks the EOI id byte, and tlast is
// set on the final result caused by one input byte.
// Each input byte yields zero, one or two output transactions. A byte is
// processed in the cycle it is accepted and its results are queued for
// m_axis. One byte is accepted per cycle as long as the result queue
// (OUT_DEPTH entries) has room for two more results; bytes that yield two
// results drain at one result per cycle, set by the single output port,
// while the receiver is ready. Input is accepted while earlier results
// wait on a stalled receiver, until fewer than two entries are free; queued
// results hold steady under backpressure. Reset empties the queue, returns
// the parser to hunting for SOI and sets the discard marker id to 0xF0.
// cfg_wr_en writes discard_marker_id; write it only while the block is idle.
module jpeg_marker_frame_filter #(
  parameter int OUT_DEPTH = jmff_pkg::OUT_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,     // discard_marker_id
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic [1:0] m_axis_tuser,    // [0] frame_start, [1] frame_end
  output logic       m_axis_tlast
);
  import jmff_pkg::*;

  logic         in_fire;
  result_pair_t res;
  result_t      head;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  jmff_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_byte     (s_axis_tdata),
    .res         (res)
  );

  jmff_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_fire  (in_fire),
    .push       (res),
    .can_accept (s_axis_tready),
    .head_valid (m_axis_tvalid),
    .head       (head),
    .pop        (m_axis_tready)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.frame_end, head.frame_start};
  assign m_axis_tlast = head.last;

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    in_fire && res.count == 2'd2 |-> !res.r0.last && res.r1.last)
    else $error("result pair with wrong last marking");

  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == MARK_BYTE && !m_axis_tlast)
    else $error("frame_start not on a leading 0xFF");

  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == ID_EOI && m_axis_tlast)
    else $error("frame_end not on the EOI id byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
